FILE: sv/ssba_pkg.sv
`default_nettype none

package ssba_pkg;

   // Map geometry
   localparam int NUM_SLOTS   = 256;
   localparam int WORD_BITS   = 32;
   localparam int NUM_WORDS   = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   // Field widths
   localparam int ADDR_W      = 48;
   localparam int SHIFT_W     = 5;
   localparam int STATUS_W    = 2;
   localparam int INDEX_W     = 8;
   localparam int CSR_IDX_W   = 1;

   // Operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASE_ADDR       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STACK_SIZE_LOG2 = 1'd1;

   localparam logic [SHIFT_W-1:0] STACK_SIZE_LOG2_RESET = 5'd14;

   // Command to the shared shift-and-add unit
   typedef struct packed {
      logic [ADDR_W-1:0]  a;
      logic [ADDR_W-1:0]  x;
      logic [SHIFT_W-1:0] amount;
      logic               shift_right;
      logic               subtract;
   } alu_op_type;

   // Write command to the free map
   typedef struct packed {
      logic                  en;
      logic [WORD_IDX_W-1:0] addr;
      logic [WORD_BITS-1:0]  data;
   } map_wr_type;

   // Read side of the free map
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic                 any;
      logic [BIT_W-1:0]     first;
   } map_rd_type;

endpackage

`default_nettype wire

FILE: sv/stack_slot_bitmap_allocator.sv
`default_nettype none

// Channel  Direction  Accepted when            Contents
// req      in         req_tvalid & req_tready   tuser: func; tdata: stack_top
// rsp      out        rsp_tvalid & rsp_tready   tdata: status, slot_index, top_address
// csr      in         csr_valid & csr_ready     csr_index selects, csr_data is written
//
// An allocate transaction scans the free map one word per cycle, then the
// ST_ADDR state forms the top address in the shared shift/add unit. A free
// transaction uses the same unit twice (subtract, shift) and one map check.
// The result is held until rsp_tready; req_tready is low from accept until
// the result is taken. Synchronous reset marks every slot free at once.

module stack_slot_bitmap_allocator import ssba_pkg::*; (
   input  wire                   clock,
   input  wire                   reset,
   // request: tuser[0] func; tdata[47:0] stack_top
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire [0:0]             req_tuser,
   input  wire [47:0]            req_tdata,
   // response: tdata[1:0] status, [9:2] slot_index, [57:10] top_address, [63:58] zero
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [63:0]           rsp_tdata,
   // configuration writes
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [ADDR_W-1:0]      csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_ADDR  = 3'd2;
   localparam logic [2:0] ST_DIFF  = 3'd3;
   localparam logic [2:0] ST_QUOT  = 3'd4;
   localparam logic [2:0] ST_CHECK = 3'd5;
   localparam logic [2:0] ST_RESP  = 3'd6;

   localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(NUM_WORDS - 1);

   logic [2:0]              state_ff;
   logic [WORD_IDX_W-1:0]   word_ff;
   logic [ADDR_W-1:0]       stack_top_ff;
   logic [ADDR_W-1:0]       acc_ff;
   logic [SLOT_W:0]         slot_plus_ff;
   logic [ADDR_W-1:0]       base_ff;
   logic [SHIFT_W-1:0]      shift_ff;
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     status_ff;
   logic [INDEX_W-1:0]      slot_ff;
   logic [ADDR_W-1:0]       top_ff;

   alu_op_type              alu_op;
   logic [ADDR_W-1:0]       alu_result;
   map_wr_type              map_wr;
   map_rd_type              map_rd;
   logic [WORD_IDX_W-1:0]   map_addr;

   logic [SLOT_W-1:0]       scan_slot;
   logic [SLOT_W-1:0]       free_slot;
   logic [WORD_IDX_W-1:0]   free_word;
   logic [BIT_W-1:0]        free_bit;
   logic                    free_bad;
   logic                    free_is_set;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, top_ff, slot_ff, status_ff};

   // Decode the slot under the scan and the slot named by a free
   assign scan_slot   = SLOT_W'({word_ff, map_rd.first});
   assign free_slot   = acc_ff[SLOT_W-1:0] - SLOT_W'(1);
   assign free_word   = WORD_IDX_W'(free_slot >> BIT_W);
   assign free_bit    = free_slot[BIT_W-1:0];
   assign free_bad    = (acc_ff == '0) || (acc_ff > ADDR_W'(NUM_SLOTS));
   assign free_is_set = map_rd.word[free_bit];
   assign map_addr    = (state_ff == ST_CHECK) ? free_word : word_ff;

   ssba_alu u_alu (
      .op     (alu_op),
      .result (alu_result)
   );

   ssba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (map_addr),
      .wr      (map_wr),
      .rd      (map_rd)
   );

   // Drive the shared unit and the map write for the current step
   always_comb begin
      alu_op = '0;
      map_wr = '0;
      unique case (state_ff)
         ST_SCAN: begin
            map_wr.en   = map_rd.any;
            map_wr.addr = word_ff;
            map_wr.data = map_rd.word & ~(WORD_BITS'(1) << map_rd.first);
         end
         ST_ADDR: begin
            alu_op.a      = base_ff;
            alu_op.x      = ADDR_W'(slot_plus_ff);
            alu_op.amount = shift_ff;
         end
         ST_DIFF: begin
            alu_op.a        = stack_top_ff;
            alu_op.x        = base_ff;
            alu_op.subtract = 1'b1;
         end
         ST_QUOT: begin
            alu_op.x           = acc_ff;
            alu_op.amount      = shift_ff;
            alu_op.shift_right = 1'b1;
         end
         ST_CHECK: begin
            map_wr.en   = !free_bad && !free_is_set;
            map_wr.addr = free_word;
            map_wr.data = map_rd.word | (WORD_BITS'(1) << free_bit);
         end
         default: begin
         end
      endcase
   end

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         shift_ff <= STACK_SIZE_LOG2_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BASE_ADDR:       base_ff  <= csr_data;
            REG_STACK_SIZE_LOG2: shift_ff <= csr_data[SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequence one transaction through scan or decode, then hold the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         word_ff      <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  stack_top_ff <= req_tdata;
                  word_ff      <= '0;
                  state_ff     <= (req_tuser[0] == FUNC_ALLOC) ? ST_SCAN : ST_DIFF;
               end
            end
            ST_SCAN: begin
               if (map_rd.any) begin
                  slot_plus_ff <= {1'b0, scan_slot} + (SLOT_W + 1)'(1);
                  slot_ff      <= INDEX_W'(scan_slot);
                  state_ff     <= ST_ADDR;
               end else if (word_ff == LAST_WORD) begin
                  status_ff    <= STATUS_NO_FREE;
                  slot_ff      <= '0;
                  top_ff       <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_RESP;
               end else begin
                  word_ff <= word_ff + WORD_IDX_W'(1);
               end
            end
            ST_ADDR: begin
               status_ff    <= STATUS_OK;
               top_ff       <= alu_result;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_RESP;
            end
            ST_DIFF: begin
               acc_ff   <= alu_result;
               state_ff <= ST_QUOT;
            end
            ST_QUOT: begin
               acc_ff   <= alu_result;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               top_ff       <= '0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_RESP;
               if (free_bad) begin
                  status_ff <= STATUS_BAD_ADDR;
                  slot_ff   <= '0;
               end else begin
                  status_ff <= free_is_set ? STATUS_NOT_ALLOC : STATUS_OK;
                  slot_ff   <= INDEX_W'(free_slot);
               end
            end
            ST_RESP: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   // One transaction in flight: never accept while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a response is pending");

   // An accepted request closes the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request side stayed open after accept");

   // A failed transaction reports no address
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] != STATUS_OK)) |-> (rsp_tdata[57:10] == '0))
      else $error("nonzero address on a failed response");

   // Running out of slots reports slot zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == STATUS_NO_FREE)) |-> (rsp_tdata[9:2] == '0))
      else $error("nonzero slot on a no-free response");

endmodule

`default_nettype wire

FILE: sv/ssba_alu.sv
`default_nettype none

module ssba_alu import ssba_pkg::*; (
   input  wire alu_op_type        op,
   output logic [ADDR_W-1:0]      result
);

   logic [ADDR_W-1:0] shifted;
   logic [ADDR_W-1:0] operand;

   // Shift the second operand, then add or subtract it from the first
   always_comb begin
      shifted = op.shift_right ? (op.x >> op.amount) : (op.x << op.amount);
      operand = op.subtract ? ~shifted : shifted;
      result  = op.a + operand + ADDR_W'(op.subtract);
   end

endmodule

`default_nettype wire

FILE: sv/ssba_map.sv
`default_nettype none

module ssba_map import ssba_pkg::*; (
   input  wire                   clock,
   input  wire                   reset,
   input  wire [WORD_IDX_W-1:0]  rd_addr,
   input  wire map_wr_type       wr,
   output map_rd_type            rd
);

   logic [WORD_BITS-1:0] words_ff [NUM_WORDS];

   // Hold one free bit per slot; every slot is free after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            words_ff[i] <= '1;
         end
      end else if (wr.en) begin
         words_ff[wr.addr] <= wr.data;
      end
   end

   // Read the selected word and find its lowest free bit
   always_comb begin
      rd.word  = words_ff[rd_addr];
      rd.any   = 1'b0;
      rd.first = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (rd.word[i]) begin
            rd.any   = 1'b1;
            rd.first = BIT_W'(i);
         end
      end
   end

endmodule

`default_nettype wire
